// ----- rtl/smf_pkg.sv -----
// Shared constants and types for the series median filter.
`default_nettype none
package smf_pkg;

  localparam int SERIES_LEN = 16;
  localparam int SMP_W      = 16;
  localparam int HELD_W     = 5;
  localparam int CNT_W      = $clog2(SERIES_LEN + 1);
  localparam int IDX_W      = $clog2(SERIES_LEN);
  localparam int MIN_MED    = 3;

  typedef struct packed {
    logic                    start;
    logic signed [SMP_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } smf_cmd_t;

  typedef struct packed {
    logic                    done;
    logic                    med_ok;
    logic signed [SMP_W-1:0] med;
  } smf_sts_t;

endpackage
`default_nettype wire

// ----- rtl/series_median_filter.sv -----
// Top level of the series median filter: handshakes, series count, median and result register.
`default_nettype none
// Running median over a series of up to SERIES_LEN signed samples (16 here).
// Each accepted item yields exactly one result item. Samples are kept in
// ascending order in a single-port-write RAM by insertion: an item walks
// down the RAM one entry per cycle, and once MIN_MED samples are held the
// two middle entries are read for the median. An item arriving on a full
// series closes it; its result is loaded into the output register once that
// register is free. The next item is taken as soon as the previous result
// sits in the output register.
module series_median_filter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [smf_pkg::SMP_W-1:0] in_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_series_done,
  output logic signed [smf_pkg::SMP_W-1:0]  out_median_value,
  output logic                              out_median_valid,
  output logic [smf_pkg::HELD_W-1:0]        out_samples_held
);
  import smf_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    pend_r, pend_nxt;
  logic                    closed_r, closed_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SMP_W-1:0] median_r, median_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_done_r, out_done_nxt;
  logic signed [SMP_W-1:0] out_med_r, out_med_nxt;
  logic                    out_mok_r, out_mok_nxt;
  logic [HELD_W-1:0]       out_held_r, out_held_nxt;

  logic                    accept, load, full;
  smf_cmd_t                cmd;
  smf_sts_t                sts;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign full     = count_r >= CNT_W'(SERIES_LEN);
  assign load     = pend_r && (!out_valid_r || out_ready);

  assign cmd.start = accept && !full;
  assign cmd.value = in_sample;
  assign cmd.count = count_r;

  smf_sorter u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    closed_nxt    = closed_r;
    count_nxt     = count_r;
    median_nxt    = median_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_done_nxt  = out_done_r;
    out_med_nxt   = out_med_r;
    out_mok_nxt   = out_mok_r;
    out_held_nxt  = out_held_r;
    if (accept) begin
      busy_nxt = 1'b1;
      if (full) begin
        // sample dropped, series closed; median stays for this result
        count_nxt  = '0;
        closed_nxt = 1'b1;
        pend_nxt   = 1'b1;
      end else begin
        closed_nxt = 1'b0;
        if (count_r == '0) begin
          median_nxt = '0;
        end
      end
    end
    if (sts.done) begin
      count_nxt = count_r + CNT_W'(1);
      if (sts.med_ok) begin
        median_nxt = sts.med;
      end
      pend_nxt = 1'b1;
    end
    if (load) begin
      busy_nxt      = 1'b0;
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_done_nxt  = closed_r;
      out_med_nxt   = median_r;
      out_mok_nxt   = count_r >= CNT_W'(MIN_MED);
      out_held_nxt  = HELD_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      median_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      median_r    <= median_nxt;
      out_valid_r <= out_valid_nxt;
    end
    closed_r   <= closed_nxt;
    out_done_r <= out_done_nxt;
    out_med_r  <= out_med_nxt;
    out_mok_r  <= out_mok_nxt;
    out_held_r <= out_held_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_series_done  = out_done_r;
  assign out_median_value = out_med_r;
  assign out_median_valid = out_mok_r;
  assign out_samples_held = out_held_r;

`ifndef SYNTH
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> busy_r)
    else $error("result pending with no item in flight");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SERIES_LEN))
    else $error("series count beyond series length");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> busy_r && !pend_r)
    else $error("sorter finished outside an item");
  a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r && !busy_r)
    else $error("result load did not free the input side");
`endif

endmodule
`default_nettype wire

// ----- rtl/smf_sorter.sv -----
// Sorted sample store: insertion walk over a synchronous RAM and median read-out.
`default_nettype none
module smf_sorter (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire smf_pkg::smf_cmd_t cmd,
  output smf_pkg::smf_sts_t     sts
);
  import smf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_PLACE, S_MID1, S_MID2, S_MID3
  } state_t;

  logic signed [SMP_W-1:0] mem [SERIES_LEN];
  logic signed [SMP_W-1:0] rdata_r;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [SMP_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [SMP_W-1:0] lo_r, lo_nxt;
  logic                    done_r, done_nxt;
  logic                    med_ok_r, med_ok_nxt;
  logic signed [SMP_W-1:0] med_r, med_nxt;

  logic                    we;
  logic [IDX_W-1:0]        waddr, raddr;
  logic signed [SMP_W-1:0] wdata;
  logic [IDX_W-1:0]        half;
  logic signed [SMP_W:0]   pair_sum;

  assign half     = IDX_W'(n_r >> 1);
  assign pair_sum = {lo_r[SMP_W-1], lo_r} + {rdata_r[SMP_W-1], rdata_r};

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    n_nxt      = n_r;
    lo_nxt     = lo_r;
    done_nxt   = 1'b0;
    med_ok_nxt = med_ok_r;
    med_nxt    = med_r;
    we         = 1'b0;
    waddr      = pos_r;
    wdata      = val_r;
    raddr      = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          val_nxt = cmd.value;
          n_nxt   = cmd.count + CNT_W'(1);
          if (cmd.count == '0) begin
            // first sample of a series lands at the bottom
            we         = 1'b1;
            waddr      = '0;
            wdata      = cmd.value;
            done_nxt   = 1'b1;
            med_ok_nxt = 1'b0;
          end else begin
            raddr     = IDX_W'(cmd.count - CNT_W'(1));
            pos_nxt   = IDX_W'(cmd.count);
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (rdata_r > val_r) begin
          // shift the larger entry up one slot, fetch the next one down
          we      = 1'b1;
          wdata   = rdata_r;
          pos_nxt = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            raddr = pos_r - IDX_W'(2);
          end
        end else begin
          we = 1'b1;
          if (n_r >= CNT_W'(MIN_MED)) begin
            state_nxt = S_MID1;
          end else begin
            state_nxt  = S_IDLE;
            done_nxt   = 1'b1;
            med_ok_nxt = 1'b0;
          end
        end
      end
      S_PLACE: begin
        we = 1'b1;
        if (n_r >= CNT_W'(MIN_MED)) begin
          state_nxt = S_MID1;
        end else begin
          state_nxt  = S_IDLE;
          done_nxt   = 1'b1;
          med_ok_nxt = 1'b0;
        end
      end
      S_MID1: begin
        raddr     = half - IDX_W'(1);
        state_nxt = S_MID2;
      end
      S_MID2: begin
        lo_nxt    = rdata_r;
        raddr     = half;
        state_nxt = S_MID3;
      end
      S_MID3: begin
        // odd count: upper middle entry; even: floor average of the pair
        med_nxt    = n_r[0] ? rdata_r : pair_sum[SMP_W:1];
        med_ok_nxt = 1'b1;
        done_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      done_r   <= 1'b0;
      med_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      med_ok_r <= med_ok_nxt;
    end
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    n_r   <= n_nxt;
    lo_r  <= lo_nxt;
    med_r <= med_nxt;
  end

  assign sts.done   = done_r;
  assign sts.med_ok = med_ok_r;
  assign sts.med    = med_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == S_IDLE)
    else $error("sorter started while busy");
  a_cmp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> pos_r != '0)
    else $error("compare step at bottom slot");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
  a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MID1 |-> n_r >= CNT_W'(MIN_MED))
    else $error("median read with too few samples");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_series_median_filter.sv -----
// Testbench for series_median_filter: random-paced samples checked against a running-median predictor.
`timescale 1ns / 1ps

typedef logic signed [smf_pkg::SMP_W-1:0] sample_t;
typedef logic [smf_pkg::HELD_W-1:0]        held_t;

typedef struct {
  logic    done;
  sample_t median;
  logic    median_ok;
  held_t   held;
} tick_result_t;

class median_scoreboard;
  localparam int LEN = smf_pkg::SERIES_LEN;

  sample_t      sorted_run[LEN];
  int           held;
  sample_t      median;
  tick_result_t awaited[$];
  int           mismatches;
  int           noted;
  int           checked;
  int           closed;
  int           even_medians;

  function new();
    held         = 0;
    median       = '0;
    mismatches   = 0;
    noted        = 0;
    checked      = 0;
    closed       = 0;
    even_medians = 0;
  endfunction

  // Works out the result of one accepted sample and queues it.
  function void note_sample(sample_t s);
    tick_result_t             r;
    int                       pos;
    int                       half;
    logic signed [smf_pkg::SMP_W:0] pair_sum;
    r.done = 1'b0;
    if (held >= LEN) begin
      // full series: sample dropped, median left as it was
      held   = 0;
      r.done = 1'b1;
      closed++;
    end else begin
      if (held == 0) median = '0;
      pos = held;
      while (pos > 0 && sorted_run[pos-1] > s) begin
        sorted_run[pos] = sorted_run[pos-1];
        pos--;
      end
      sorted_run[pos] = s;
      held++;
      if (held >= smf_pkg::MIN_MED) begin
        half = held / 2;
        if (held % 2 == 0) begin
          pair_sum = sorted_run[half-1] + sorted_run[half];
          median   = sample_t'(pair_sum >>> 1);
          even_medians++;
        end else begin
          median = sorted_run[half];
        end
      end
    end
    r.median    = median;
    r.median_ok = (held >= smf_pkg::MIN_MED);
    r.held      = held_t'(held);
    awaited.push_back(r);
    noted++;
  endfunction

  function void check_result(tick_result_t got);
    tick_result_t exp;
    if (awaited.size() == 0) begin
      $error("result item with nothing expected: done %0d median %0d valid %0d held %0d",
             got.done, got.median, got.median_ok, got.held);
      mismatches++;
      return;
    end
    exp = awaited.pop_front();
    checked++;
    if (got.done !== exp.done) begin
      $error("series_done: expected %0d, got %0d", exp.done, got.done);
      mismatches++;
    end
    if (got.median !== exp.median) begin
      $error("median_value: expected %0d, got %0d", exp.median, got.median);
      mismatches++;
    end
    if (got.median_ok !== exp.median_ok) begin
      $error("median_valid: expected %0d, got %0d", exp.median_ok, got.median_ok);
      mismatches++;
    end
    if (got.held !== exp.held) begin
      $error("samples_held: expected %0d, got %0d", exp.held, got.held);
      mismatches++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_series_median_filter;
  import smf_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 40;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY4, READY_SPARSE} stall_mode_t;
  typedef enum int {SMP_FULL, SMP_CLUSTER, SMP_RAILS, SMP_NEAR_RAIL} sample_mode_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  sample_t in_sample = '0;
  logic    out_ready = 1'b0;
  logic    in_ready;
  logic    out_valid;
  logic    out_series_done;
  sample_t out_median_value;
  logic    out_median_valid;
  held_t   out_samples_held;

  median_scoreboard board = new();

  int           cycles     = 0;
  int           burst_left = 0;
  stall_mode_t  stall_mode = READY_ALWAYS;
  int           stall_left = 0;
  int           stall_phase = 0;
  logic         ready_next;
  tick_result_t seen;

  // full range both ways, odd sum of middles, bit patterns, a closed series and the start of the next
  int directed[21] = '{32767, -32768, 0, -1, 1, 32767, -32768, -32768, 32767, 12345,
                       -12346, 21845, -21846, 1, -1, 0, 100, -5, -32768, 32767, 32767};
  int rails[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  series_median_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_series_done  (out_series_done),
    .out_median_value (out_median_value),
    .out_median_valid (out_median_valid),
    .out_samples_held (out_samples_held)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: checks result items and stalls in changing patterns.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.done      = out_series_done;
      seen.median    = out_median_value;
      seen.median_ok = out_median_valid;
      seen.held      = out_samples_held;
      board.check_result(seen);
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 200);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      READY_ALWAYS: ready_next = 1'b1;
      READY_COIN:   ready_next = 1'($urandom_range(0, 1));
      READY_EVERY4: ready_next = (stall_phase % 4 != 0);
      default:      ready_next = ($urandom_range(0, 7) == 0);
    endcase
    out_ready <= rst_n ? ready_next : 1'b0;
  end

  task automatic send_sample(sample_t s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s);
  endtask

  // Bursts of back-to-back items with idle gaps of random length between them.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  function automatic sample_t pick_sample(sample_mode_t m);
    case (m)
      SMP_FULL:    return sample_t'($urandom);
      SMP_CLUSTER: return sample_t'(int'($urandom_range(0, 8)) - 4);
      SMP_RAILS:   return sample_t'(rails[$urandom_range(0, 6)]);
      default:     return $urandom_range(0, 1) ? sample_t'(32767 - int'($urandom_range(0, 15)))
                                               : sample_t'(-32768 + int'($urandom_range(0, 15)));
    endcase
  endfunction

  initial begin
    sample_mode_t mode;
    mode = SMP_FULL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_sample(sample_t'(directed[i]));
      pace_sender();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 16) == 0) mode = sample_mode_t'($urandom_range(0, 3));
      send_sample(pick_sample(mode));
      if (n < RANDOM_ITEMS - 1) pace_sender();
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results for %0d samples: %0d series closed, %0d even-count medians",
             board.checked, board.noted, board.closed, board.even_medians);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/smf_pkg.sv
rtl/smf_sorter.sv
rtl/series_median_filter.sv
sim/tb_series_median_filter.sv
